FILE: hdl/lpbt_pkg.sv
// shared types and constants of the led pixel bit transposer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lpbt_pkg;

    // fixed layout of the block
    localparam int STRIP_COUNT    = 8;
    localparam int BYTES_PER_RGB  = 24;
    localparam int BYTES_PER_RGBW = 32;

    // widths: span address holds (1024 * 32) + 32, bit count holds 32
    localparam int SPAN_W       = 17;
    localparam int NBITS_W      = 6;
    localparam int ADDR_FIELD_W = 15;
    localparam int WORD_W       = 32;

    // opcodes
    localparam logic [1:0] OP_RGB   = 2'd0;
    localparam logic [1:0] OP_RGBW  = 2'd1;
    localparam logic [1:0] OP_GAMMA = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // pixel formats
    localparam logic [1:0] FMT_RGB    = 2'd0;
    localparam logic [1:0] FMT_BRIGHT = 2'd1;
    localparam logic [1:0] FMT_FLAG   = 2'd2;

    // register indexes (paddr bit 2)
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_BRIGHT = 1'b1;

    localparam logic [7:0] FLAG_MARK    = 8'hC0;
    localparam logic [7:0] BRIGHT_RESET = 8'hFF;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [2:0]              strip_port;
        logic [9:0]              pixel_number;
        logic [7:0]              red_level;
        logic [7:0]              green_level;
        logic [7:0]              blue_level;
        logic [7:0]              white_level;
        logic [7:0]              gamma_slot;
        logic [7:0]              gamma_value;
        logic [ADDR_FIELD_W-1:0] store_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0]              store_byte;
        logic [ADDR_FIELD_W-1:0] byte_address;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } t_gamma_set;

    typedef struct packed {
        logic                    start;
        logic [2:0]              strip;
        logic [SPAN_W-1:0]       base;
        logic [NBITS_W-1:0]      nbits;
        logic [WORD_W-1:0]       word;
        logic [ADDR_FIELD_W-1:0] rd_addr;
    } t_spread_cmd;

    typedef struct packed {
        logic ready;
        logic clearing;
    } t_spread_stat;

endpackage

FILE: hdl/lpbt_gamma.sv
// gamma table memory and four-level lookup sequencer
// depends on lpbt_pkg
`timescale 1ns / 1ps

module lpbt_gamma (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [7:0]            i_wr_slot,
    input  logic [7:0]            i_wr_value,
    input  logic                  i_start,
    input  lpbt_pkg::t_gamma_set  i_levels,
    output logic                  o_done,
    output lpbt_pkg::t_gamma_set  o_mapped
);
    import lpbt_pkg::*;

    localparam int LOOKUPS = 4;

    logic [7:0]        r_mem [0:255];
    logic [7:0]        r_q;
    logic [WORD_W-1:0] r_lv;
    logic [WORD_W-1:0] r_col;
    logic [2:0]        r_cnt;
    logic              r_run;
    logic              r_cap;
    logic              r_done;
    logic              w_issue;
    logic              w_last;

    assign w_issue = r_run && (r_cnt != 3'(LOOKUPS));
    assign w_last  = r_cap && (r_cnt == 3'(LOOKUPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cap  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_cap  <= w_issue;
            r_done <= w_last;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (w_issue) begin
                r_cnt <= r_cnt + 3'd1;
            end else if (w_last) begin
                r_run <= 1'b0;
            end
        end
    end

    // levels leave red first; mapped bytes enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lv <= i_levels;
        end else if (w_issue) begin
            r_lv <= {r_lv[WORD_W-9:0], 8'h00};
        end
        if (r_cap) begin
            r_col <= {r_col[WORD_W-9:0], r_q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot] <= i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[r_lv[WORD_W-1:WORD_W-8]];
    end

    assign o_done   = r_done;
    assign o_mapped = t_gamma_set'(r_col);

endmodule

FILE: hdl/lpbt_spreader.sv
// frame store memory with reset clearing pass and bit-serial read-modify-write
// depends on lpbt_pkg
`timescale 1ns / 1ps

module lpbt_spreader #(
    parameter int STORE_BYTES = 32768
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lpbt_pkg::t_spread_cmd  i_cmd,
    output lpbt_pkg::t_spread_stat o_stat,
    output logic [7:0]             o_rd_data
);
    import lpbt_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);
    localparam int XW = (AW > SPAN_W) ? AW : SPAN_W;

    logic [7:0]         r_mem [0:STORE_BYTES-1];
    logic [7:0]         r_q;
    logic               r_clearing;
    logic [AW-1:0]      r_clr_idx;
    logic               r_busy;
    logic [XW-1:0]      r_addr;
    logic [NBITS_W-1:0] r_left;
    logic [WORD_W-1:0]  r_word;
    logic [2:0]         r_strip;
    logic               r_wb_valid;
    logic [AW-1:0]      r_wb_idx;
    logic               r_wb_bit;
    logic [AW-1:0]      w_rd_idx;
    logic [XW-1:0]      w_rd_wide;
    logic [7:0]         w_mask;
    logic [7:0]         w_merged;

    assign w_rd_wide = XW'(i_cmd.rd_addr);
    assign w_rd_idx  = r_busy ? r_addr[AW-1:0] : w_rd_wide[AW-1:0];
    assign w_mask    = 8'(1) << r_strip;
    assign w_merged  = r_wb_bit ? (r_q | w_mask) : (r_q & ~w_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_busy     <= 1'b0;
            r_left     <= '0;
            r_wb_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                if (r_clr_idx == AW'(STORE_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + AW'(1);
                end
            end
            r_wb_valid <= r_busy;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_left <= i_cmd.nbits;
            end else if (r_busy) begin
                r_left <= r_left - NBITS_W'(1);
                if (r_left == NBITS_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // one store byte per cycle: read now, merge the strip bit next cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_addr  <= XW'(i_cmd.base);
            r_word  <= i_cmd.word;
            r_strip <= i_cmd.strip;
        end else if (r_busy) begin
            r_addr <= r_addr + XW'(1);
            r_word <= {r_word[WORD_W-2:0], 1'b0};
        end
        r_wb_idx <= r_addr[AW-1:0];
        r_wb_bit <= r_word[WORD_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= 8'h00;
        end else if (r_wb_valid) begin
            r_mem[r_wb_idx] <= w_merged;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[w_rd_idx];
    end

    assign o_stat.clearing = r_clearing;
    assign o_stat.ready    = !r_clearing && !r_busy && !r_wb_valid;
    assign o_rd_data       = r_q;

endmodule

FILE: hdl/led_pixel_bit_transposer.sv
// Bit-transposing frame store for eight parallel LED strips: bit p of every store
// byte belongs to strip p. After reset the frame store is cleared one byte per
// cycle; no item is accepted while it clears (register writes still are). Items
// run one at a time. A pixel write covers N store bytes, N being 24 for three-byte
// strips and 32 for four-byte layouts: a gamma lookup of its levels on the table's
// single read port, then, unless the write is dropped, one read-modify-write of a
// store byte per cycle on the frame store port. A gamma load is written into the
// table in the cycle it is accepted; a store read waits while an earlier result
// still waits unaccepted in the output register, then reads the frame store and
// loads its result into the output register.
// depends on lpbt_pkg, lpbt_gamma, lpbt_spreader
`timescale 1ns / 1ps

module led_pixel_bit_transposer #(
    parameter int STORE_BYTES = 32768
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lpbt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lpbt_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import lpbt_pkg::*;

    localparam logic [31:0] LIMIT = 32'(STORE_BYTES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_GAMMA  = 3'd1;
    localparam logic [2:0] S_SPREAD = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_RDDATA = 3'd4;

    logic [2:0]              r_state;
    logic [2:0]              n_state;
    logic [1:0]              r_fmt;
    logic [7:0]              r_bright;
    logic [1:0]              r_op;
    logic [2:0]              r_strip;
    logic [SPAN_W-1:0]       r_base;
    logic [NBITS_W-1:0]      r_nbits;
    logic                    r_drop;
    logic [ADDR_FIELD_W-1:0] r_raddr;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    w_accept;
    logic                    w_cfg_wr;
    logic                    w_gwr;
    logic                    w_gstart;
    logic                    w_gdone;
    t_gamma_set              w_levels;
    t_gamma_set              w_mapped;
    t_spread_cmd             w_cmd;
    t_spread_stat            w_stat;
    logic [7:0]              w_rd_data;
    logic                    w_out_load;
    t_out_item               w_out_data;
    logic [SPAN_W-1:0]       w_pix;
    logic [SPAN_W-1:0]       w_base;
    logic [SPAN_W-1:0]       w_span;
    logic [SPAN_W-1:0]       w_end;
    logic                    w_drop;
    logic                    w_rd_in;
    logic [WORD_W-1:0]       w_word;
    logic [7:0]              w_flag;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_RGB;
            r_bright <= BRIGHT_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_BRIGHT) begin
                r_bright <= pwdata[7:0];
            end else begin
                r_fmt <= pwdata[1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_BRIGHT) ? {24'h000000, r_bright} : {30'h0, r_fmt};

    // layout of the accepted pixel
    assign w_pix = SPAN_W'(i_in_item.pixel_number);

    always_comb begin
        if (i_in_item.opcode == OP_RGBW) begin
            w_base = w_pix * SPAN_W'(BYTES_PER_RGBW);
            w_span = SPAN_W'(BYTES_PER_RGBW);
        end else if (r_fmt == FMT_RGB) begin
            w_base = w_pix * SPAN_W'(BYTES_PER_RGB);
            w_span = SPAN_W'(BYTES_PER_RGB);
        end else begin
            w_base = (w_pix + SPAN_W'(1)) * SPAN_W'(BYTES_PER_RGBW);
            w_span = SPAN_W'(BYTES_PER_RGBW);
        end
    end

    assign w_end  = w_base + w_span;
    assign w_drop = ({1'b0, i_in_item.strip_port} >= 4'(STRIP_COUNT))
                 || ((i_in_item.opcode == OP_RGB)
                     && !(r_fmt inside {FMT_RGB, FMT_BRIGHT, FMT_FLAG}))
                 || (32'(w_end) > LIMIT);

    assign w_accept   = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_stat.ready;

    assign w_levels.red   = i_in_item.red_level;
    assign w_levels.green = i_in_item.green_level;
    assign w_levels.blue  = i_in_item.blue_level;
    assign w_levels.white = i_in_item.white_level;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_in_item.opcode;
            r_strip <= i_in_item.strip_port;
            r_base  <= w_base;
            r_nbits <= w_span[NBITS_W-1:0];
            r_drop  <= w_drop;
            r_raddr <= i_in_item.store_address;
        end
    end

    // colour bytes, first sent in the top byte
    assign w_flag = FLAG_MARK | {2'b00, ~w_mapped.blue[7:6], ~w_mapped.green[7:6],
                                 ~w_mapped.red[7:6]};

    always_comb begin
        if (r_op == OP_RGBW) begin
            w_word = {w_mapped.green, w_mapped.red, w_mapped.blue, w_mapped.white};
        end else begin
            case (r_fmt)
                FMT_BRIGHT: w_word = {r_bright, w_mapped.blue, w_mapped.green, w_mapped.red};
                FMT_FLAG:   w_word = {w_flag, w_mapped.red, w_mapped.green, w_mapped.blue};
                default:    w_word = {w_mapped.red, w_mapped.green, w_mapped.blue, 8'h00};
            endcase
        end
    end

    assign w_rd_in = 32'(r_raddr) < LIMIT;

    always_comb begin
        n_state       = r_state;
        w_gwr         = 1'b0;
        w_gstart      = 1'b0;
        w_out_load    = 1'b0;
        w_out_data    = '{store_byte: 8'h00, byte_address: r_raddr};
        w_cmd.start   = 1'b0;
        w_cmd.strip   = r_strip;
        w_cmd.base    = r_base;
        w_cmd.nbits   = r_nbits;
        w_cmd.word    = w_word;
        w_cmd.rd_addr = r_raddr;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.opcode)
                        OP_GAMMA: w_gwr = 1'b1;
                        OP_READ:  n_state = S_RDWAIT;
                        default: begin
                            w_gstart = 1'b1;
                            n_state  = S_GAMMA;
                        end
                    endcase
                end
            end
            S_GAMMA: begin
                if (w_gdone) begin
                    w_cmd.start = !r_drop;
                    n_state     = r_drop ? S_IDLE : S_SPREAD;
                end
            end
            S_SPREAD: begin
                if (w_stat.ready) begin
                    n_state = S_IDLE;
                end
            end
            S_RDWAIT: begin
                // wait until the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    if (w_rd_in) begin
                        n_state = S_RDDATA;
                    end else begin
                        w_out_load = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_RDDATA: begin
                w_out_load            = 1'b1;
                w_out_data.store_byte = w_rd_data;
                n_state               = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    lpbt_gamma u_gamma (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_gwr),
        .i_wr_slot  (i_in_item.gamma_slot),
        .i_wr_value (i_in_item.gamma_value),
        .i_start    (w_gstart),
        .i_levels   (w_levels),
        .o_done     (w_gdone),
        .o_mapped   (w_mapped)
    );

    lpbt_spreader #(
        .STORE_BYTES (STORE_BYTES)
    ) u_spreader (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .o_rd_data (w_rd_data)
    );

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> !o_in_ready)
        else $error("item accepted during frame store clear");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |->
            ($past(r_state) == S_RDWAIT || $past(r_state) == S_RDDATA))
        else $error("result appeared outside a store read");

    a_start_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> w_stat.ready)
        else $error("spread started while store engine busy");

    a_gamma_done_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gdone |-> (r_state == S_GAMMA))
        else $error("gamma lookup finished outside pixel write");
`endif

endmodule

FILE: dv/led_pixel_bit_transposer_tb.sv
// self-checking testbench of led_pixel_bit_transposer: directed layout tests, then random
// traffic under three idle patterns, checked against a frame image kept in the bench
// depends on lpbt_pkg and led_pixel_bit_transposer
`timescale 1ns / 1ps

module led_pixel_bit_transposer_tb;

    import lpbt_pkg::*;

    localparam int STORE_BYTES   = 32768;
    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT   = 4 * STORE_BYTES;
    localparam logic [1:0] FMT_UNUSED = 2'd3;
    localparam logic [7:0] TOP_BITS   = 8'hC0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // bench copy of the block state
    bit [7:0]    frame_image [STORE_BYTES];
    bit [7:0]    gamma_map [256];
    logic [1:0]  fmt_reg = FMT_RGB;
    logic [7:0]  bright_reg = BRIGHT_RESET;
    t_out_item   pending_reads [$];
    int          recent_bases [$];

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int n_errors = 0;
    int n_pixel_writes = 0;
    int n_gamma_loads = 0;
    int n_reads_checked = 0;
    int n_settings = 0;

    led_pixel_bit_transposer #(
        .STORE_BYTES(STORE_BYTES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        n_errors++;
    endtask

    // write one colour word, msb first, into the strip's bit of 8*nbytes store bytes
    function automatic void spread_levels(input logic [2:0] strip, input int base,
                                          input logic [31:0] word, input int nbytes);
        if (int'(strip) >= STRIP_COUNT || base + 8 * nbytes > STORE_BYTES)
            return;
        for (int k = 0; k < 8 * nbytes; k++)
            frame_image[base + k][strip] = word[31 - k];
    endfunction

    function automatic void update_frame_image(input t_in_item it);
        logic [7:0] gr, gg, gb, gw, flag;
        t_out_item  want;
        int         pix;
        gr  = gamma_map[it.red_level];
        gg  = gamma_map[it.green_level];
        gb  = gamma_map[it.blue_level];
        gw  = gamma_map[it.white_level];
        pix = int'(it.pixel_number);
        case (it.opcode)
            OP_RGB: begin
                n_pixel_writes++;
                case (fmt_reg)
                    FMT_RGB:
                        spread_levels(it.strip_port, pix * BYTES_PER_RGB, {gr, gg, gb, 8'h00}, 3);
                    FMT_BRIGHT:
                        spread_levels(it.strip_port, (pix + 1) * BYTES_PER_RGBW,
                                      {bright_reg, gb, gg, gr}, 4);
                    FMT_FLAG: begin
                        flag = FLAG_MARK | ((~gb & TOP_BITS) >> 2) | ((~gg & TOP_BITS) >> 4)
                             | ((~gr & TOP_BITS) >> 6);
                        spread_levels(it.strip_port, (pix + 1) * BYTES_PER_RGBW,
                                      {flag, gr, gg, gb}, 4);
                    end
                    default: ;
                endcase
            end
            OP_RGBW: begin
                n_pixel_writes++;
                spread_levels(it.strip_port, pix * BYTES_PER_RGBW, {gg, gr, gb, gw}, 4);
            end
            OP_GAMMA: begin
                n_gamma_loads++;
                gamma_map[it.gamma_slot] = it.gamma_value;
            end
            default: begin
                want.store_byte   = frame_image[it.store_address];
                want.byte_address = it.store_address;
                pending_reads.push_back(want);
            end
        endcase
    endfunction

    // fields an opcode ignores still carry random bits
    function automatic t_in_item random_fields();
        t_in_item it;
        it.opcode        = 2'($urandom_range(3));
        it.strip_port    = 3'($urandom_range(7));
        it.pixel_number  = 10'($urandom_range(1023));
        it.red_level     = 8'($urandom_range(255));
        it.green_level   = 8'($urandom_range(255));
        it.blue_level    = 8'($urandom_range(255));
        it.white_level   = 8'($urandom_range(255));
        it.gamma_slot    = 8'($urandom_range(255));
        it.gamma_value   = 8'($urandom_range(255));
        it.store_address = 15'($urandom_range(32767));
        return it;
    endfunction

    function automatic t_in_item pixel_item(input logic [1:0] op, input logic [2:0] strip,
                                            input logic [9:0] pix, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [7:0] w);
        t_in_item it;
        it = random_fields();
        it.opcode       = op;
        it.strip_port   = strip;
        it.pixel_number = pix;
        it.red_level    = r;
        it.green_level  = g;
        it.blue_level   = b;
        it.white_level  = w;
        return it;
    endfunction

    function automatic t_in_item read_item(input logic [14:0] addr);
        t_in_item it;
        it = random_fields();
        it.opcode        = OP_READ;
        it.store_address = addr;
        return it;
    endfunction

    function automatic t_in_item gamma_item(input logic [7:0] slot, input logic [7:0] value);
        t_in_item it;
        it = random_fields();
        it.opcode      = OP_GAMMA;
        it.gamma_slot  = slot;
        it.gamma_value = value;
        return it;
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        update_frame_image(it);
    endtask

    // psel drops after the access, which keeps back-to-back writes apart
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_FORMAT)
            fmt_reg = value[1:0];
        else
            bright_reg = value[7:0];
    endtask

    // block idle: every read answered, and the last pixel write given time to finish
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_layout(input logic [1:0] fmt, input logic [7:0] bright);
        drain_block();
        write_register(REG_FORMAT, {30'd0, fmt});
        write_register(REG_BRIGHT, {24'd0, bright});
        n_settings++;
    endtask

    // slot 0 maps to zero and slot 255 to full scale, the rest random
    task automatic test_gamma_table();
        logic [7:0] value;
        for (int s = 0; s < 256; s++) begin
            value = (s == 0) ? 8'h00 : (s == 255) ? 8'hFF : 8'($urandom_range(255));
            send_item(gamma_item(8'(s), value));
        end
    endtask

    task automatic test_rgb_layout();
        send_item(pixel_item(OP_RGB, 3'd0, 10'd0, 8'hFF, 8'h00, 8'hFF, 8'h00));
        send_item(read_item(15'd0));
        send_item(read_item(15'd7));
        send_item(read_item(15'd8));
        send_item(read_item(15'd23));
        send_item(pixel_item(OP_RGB, 3'd7, 10'd1023, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_item(read_item(15'd24552));
        send_item(read_item(15'd24575));
        // last rgbw pixel ends exactly at the top of the store
        send_item(pixel_item(OP_RGBW, 3'd3, 10'd1023, 8'h00, 8'hFF, 8'hFF, 8'hFF));
        send_item(read_item(15'd32767));
        send_item(read_item(15'd32736));
        send_item(pixel_item(OP_RGBW, 3'd0, 10'd0, 8'hFF, 8'h00, 8'h00, 8'hFF));
        send_item(read_item(15'd31));
    endtask

    task automatic test_header_layouts();
        set_layout(FMT_BRIGHT, 8'hFF);
        send_item(pixel_item(OP_RGB, 3'd5, 10'd0, 8'h00, 8'hFF, 8'h00, 8'h00));
        send_item(read_item(15'd32));
        send_item(read_item(15'd39));
        send_item(read_item(15'd63));
        // header layouts push pixel 1023 past the store, so the write is dropped
        send_item(pixel_item(OP_RGB, 3'd4, 10'd1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(read_item(15'd32767));
        set_layout(FMT_FLAG, 8'h00);
        send_item(pixel_item(OP_RGB, 3'd1, 10'd2, 8'hFF, 8'h00, 8'($urandom_range(255)),
                             8'h00));
        send_item(read_item(15'd96));
        send_item(read_item(15'd97));
        send_item(read_item(15'd127));
    endtask

    task automatic test_unused_format();
        set_layout(FMT_UNUSED, 8'hFF);
        send_item(pixel_item(OP_RGB, 3'd2, 10'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_item(read_item(15'd0));
    endtask

    // mostly a few pixels shared by all strips, some anywhere, some at the top
    function automatic logic [9:0] choose_pixel();
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return 10'($urandom_range(7));
        else if (p < 90)
            return 10'($urandom_range(1023));
        return 10'(1022 + $urandom_range(1));
    endfunction

    task automatic test_random_traffic(input logic [1:0] fmt, input logic [7:0] bright,
                                       input int idle_pct, input int stall_pct,
                                       input int count);
        t_in_item it;
        int       pick;
        int       base;
        set_layout(fmt, bright);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                it = pixel_item((pick < 35) ? OP_RGB : OP_RGBW, 3'($urandom_range(7)),
                                choose_pixel(), 8'($urandom_range(255)),
                                8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255)));
                if (it.opcode == OP_RGBW)
                    base = int'(it.pixel_number) * BYTES_PER_RGBW;
                else if (fmt_reg == FMT_RGB)
                    base = int'(it.pixel_number) * BYTES_PER_RGB;
                else
                    base = (int'(it.pixel_number) + 1) * BYTES_PER_RGBW;
                recent_bases.push_back(base);
                if (recent_bases.size() > 8)
                    void'(recent_bases.pop_front());
            end else if (pick < 58) begin
                it = gamma_item(8'($urandom_range(255)), 8'($urandom_range(255)));
            end else if (recent_bases.size() > 0 && $urandom_range(3) != 0) begin
                base = recent_bases[$urandom_range(recent_bases.size() - 1)];
                it = read_item(15'(base + $urandom_range(31)));
            end else begin
                it = read_item(15'($urandom_range(32767)));
            end
            send_item(it);
        end
    endtask

    always @(posedge i_clk) begin : check_reads
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("unexpected result address", o_out_item.byte_address, 0);
            end else begin
                want = pending_reads.pop_front();
                n_reads_checked++;
                if (o_out_item.store_byte !== want.store_byte)
                    report_mismatch("store_byte", o_out_item.store_byte, want.store_byte);
                if (o_out_item.byte_address !== want.byte_address)
                    report_mismatch("byte_address", o_out_item.byte_address,
                                    want.byte_address);
            end
        end
    end

    // the clearing pass after reset is the longest quiet stretch of a good run
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // registers may be written while the store is still clearing
        write_register(REG_FORMAT, {30'd0, FMT_RGB});
        write_register(REG_BRIGHT, 32'd0);
        n_settings++;
        in_idle_pct   = 14;
        out_stall_pct = 79;
        test_gamma_table();
        test_rgb_layout();
        test_header_layouts();
        test_unused_format();
        test_random_traffic(FMT_RGB, 8'h80, 14, 79, 120);
        test_random_traffic(FMT_BRIGHT, 8'hFF, 14, 79, 120);
        test_random_traffic(FMT_FLAG, 8'h00, 79, 14, 120);
        test_random_traffic(FMT_BRIGHT, 8'($urandom_range(255)), 79, 14, 120);
        test_random_traffic(FMT_FLAG, 8'($urandom_range(255)), 0, 0, 120);
        test_random_traffic(FMT_RGB, 8'($urandom_range(255)), 0, 0, 100);
        test_random_traffic(FMT_UNUSED, 8'($urandom_range(255)), 0, 0, 30);
        drain_block();
        $display("covered %0d pixel writes, %0d gamma loads, %0d store reads checked",
                 n_pixel_writes, n_gamma_loads, n_reads_checked);
        $display("over %0d register settings and three idle patterns, %0d mismatches",
                 n_settings, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
